// File: hdl/nsbd_pkg.sv
// ----------------------------------------------------------------------------
// nsbd_pkg: shared types and constants for the scaling blit address generator
// Frame geometry, register map, command codes and the beat carried down the
// divider chain.
// ----------------------------------------------------------------------------
package nsbd_pkg;

	localparam int ROW_PITCH  = 512;
	localparam int FRAME_ROWS = 272;

	localparam int POS_W     = 9;   // column / row / left / top
	localparam int SIZE_W    = 10;  // rectangle sizes, 0..1023 as written
	localparam int FRAME_W   = 2;
	localparam int CMD_W     = 2;
	localparam int PROD_W    = SIZE_W + POS_W;   // size * coordinate
	localparam int QUO_W     = SIZE_W;           // quotient up to size - 1, one bit per cell
	localparam int NUM_CELLS = QUO_W;
	localparam int COORD_W   = POS_W + 2;        // left + size - 1, with headroom
	localparam int SRC_OFF_W = 18;
	localparam int DST_OFF_W = 19;
	localparam int OFF_SUM_W = 21;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCALE  = 2'd0,
		CMD_MIRROR = 2'd1,
		CMD_TURN   = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_LEFT   = 3'd0,
		REG_SRC_TOP    = 3'd1,
		REG_SRC_WIDTH  = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_DST_LEFT   = 3'd4,
		REG_DST_TOP    = 3'd5,
		REG_DST_WIDTH  = 3'd6,
		REG_DST_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]  src_left;
		logic [POS_W-1:0]  src_top;
		logic [SIZE_W-1:0] src_width;
		logic [SIZE_W-1:0] src_height;
		logic [POS_W-1:0]  dst_left;
		logic [POS_W-1:0]  dst_top;
		logic [SIZE_W-1:0] dst_width;
		logic [SIZE_W-1:0] dst_height;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic [FRAME_W-1:0] src_frame;
		logic [FRAME_W-1:0] dst_frame;
	} item_t;

	// One divider lane: partial remainder, numerator bits still to go
	// (quotient bits shift in from the bottom), divisor.
	typedef struct packed {
		logic [SIZE_W-1:0] rem;
		logic [QUO_W-1:0]  nq;
		logic [SIZE_W-1:0] div;
	} lane_t;

	typedef struct packed {
		item_t item;
		lane_t lx;
		lane_t ly;
	} div_beat_t;

endpackage

// File: hdl/nsbd_front.sv
// ----------------------------------------------------------------------------
// nsbd_front: operand select and multiply stage
// Picks the coordinate and divisor per lane and registers size * coordinate,
// split into the first remainder and the numerator bits for the chain.
// ----------------------------------------------------------------------------
module nsbd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  nsbd_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  nsbd_pkg::item_t     in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output nsbd_pkg::div_beat_t out_beat
);
	import nsbd_pkg::*;

	logic              valid_s1;
	div_beat_t         beat_s1;
	logic              turn;
	logic [POS_W-1:0]  ax, ay;
	logic [SIZE_W-1:0] dx, dy;
	logic [PROD_W-1:0] px, py;
	logic              load;

	always_comb begin
		turn = (in_item.command == CMD_TURN);
		ax   = turn ? in_item.row : in_item.col;
		ay   = turn ? in_item.col : in_item.row;
		dx   = turn ? cfg.dst_height : cfg.dst_width;
		dy   = turn ? cfg.dst_width : cfg.dst_height;
		px   = PROD_W'(cfg.src_width) * PROD_W'(ax);
		py   = PROD_W'(cfg.src_height) * PROD_W'(ay);
	end

	assign load     = !valid_s1 || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			beat_s1.item    <= in_item;
			beat_s1.lx.rem  <= SIZE_W'(px[PROD_W-1:QUO_W]);
			beat_s1.lx.nq   <= px[QUO_W-1:0];
			beat_s1.lx.div  <= dx;
			beat_s1.ly.rem  <= SIZE_W'(py[PROD_W-1:QUO_W]);
			beat_s1.ly.nq   <= py[QUO_W-1:0];
			beat_s1.ly.div  <= dy;
		end
	end

	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

endmodule

// File: hdl/nsbd_div_cell.sv
// ----------------------------------------------------------------------------
// nsbd_div_cell: one restoring-division step for both lanes
// Shifts one numerator bit into the remainder, subtracts the divisor when it
// fits and shifts the quotient bit in. Item payload rides along.
// ----------------------------------------------------------------------------
module nsbd_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nsbd_pkg::div_beat_t in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output nsbd_pkg::div_beat_t out_beat
);
	import nsbd_pkg::*;

	function automatic lane_t div_step(input lane_t l);
		logic [SIZE_W:0] trial;
		logic            fits;
		lane_t           r;
		trial = {l.rem, l.nq[QUO_W-1]};
		fits  = (trial >= {1'b0, l.div});
		r.div = l.div;
		r.rem = fits ? SIZE_W'(trial - {1'b0, l.div}) : trial[SIZE_W-1:0];
		r.nq  = {l.nq[QUO_W-2:0], fits};
		return r;
	endfunction

	logic      valid_q;
	div_beat_t beat_q;
	logic      load;

	assign load     = !valid_q || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			beat_q.item <= in_beat.item;
			beat_q.lx   <= div_step(in_beat.lx);
			beat_q.ly   <= div_step(in_beat.ly);
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

// File: hdl/nsbd_back.sv
// ----------------------------------------------------------------------------
// nsbd_back: source coordinate, bounds check and offset stage
// Forms the source and destination offsets and the write enable, and holds
// the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module nsbd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsbd_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  nsbd_pkg::div_beat_t           in_beat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nsbd_pkg::FRAME_W-1:0]  src_frame_sel,
	output logic [nsbd_pkg::SRC_OFF_W-1:0] src_offset,
	output logic [nsbd_pkg::FRAME_W-1:0]  dst_frame_sel,
	output logic [nsbd_pkg::DST_OFF_W-1:0] dst_offset,
	output logic                          write_enable
);
	import nsbd_pkg::*;

	logic [COORD_W-1:0]   sx, sy, fwd_x, fwd_y, rev_x, rev_y;
	logic [COORD_W-1:0]   drow;
	logic [OFF_SUM_W-1:0] soff_full, doff_full;
	logic                 we;
	logic                 sizes_ok, inside_ok, cmd_ok, frame_ok;
	logic                 load;

	logic                 valid_q;
	logic [FRAME_W-1:0]   sfs_q, dfs_q;
	logic [SRC_OFF_W-1:0] soff_q;
	logic [DST_OFF_W-1:0] doff_q;
	logic                 we_q;

	always_comb begin
		fwd_x = COORD_W'(cfg.src_left) + COORD_W'(in_beat.lx.nq);
		fwd_y = COORD_W'(cfg.src_top) + COORD_W'(in_beat.ly.nq);
		rev_x = COORD_W'(cfg.src_left) + COORD_W'(cfg.src_width) - COORD_W'(1)
			- COORD_W'(in_beat.lx.nq);
		rev_y = COORD_W'(cfg.src_top) + COORD_W'(cfg.src_height) - COORD_W'(1)
			- COORD_W'(in_beat.ly.nq);

		cmd_ok = 1'b1;
		sx     = fwd_x;
		sy     = fwd_y;
		case (in_beat.item.command)
			CMD_SCALE: begin
				sx = fwd_x;
				sy = fwd_y;
			end
			CMD_MIRROR: begin
				sx = rev_x;
				sy = rev_y;
			end
			CMD_TURN: begin
				sx = rev_x;
				sy = fwd_y;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase

		sizes_ok  = (cfg.src_width != '0) && (cfg.src_height != '0)
			&& (cfg.dst_width != '0) && (cfg.dst_height != '0);
		inside_ok = (SIZE_W'(in_beat.item.col) < cfg.dst_width)
			&& (SIZE_W'(in_beat.item.row) < cfg.dst_height);
		frame_ok  = (sx < COORD_W'(ROW_PITCH)) && (sy < COORD_W'(FRAME_ROWS));
		we        = sizes_ok && inside_ok && cmd_ok && frame_ok;

		soff_full = OFF_SUM_W'(sy) * OFF_SUM_W'(ROW_PITCH) + OFF_SUM_W'(sx);
		drow      = COORD_W'(cfg.dst_top) + COORD_W'(in_beat.item.row);
		doff_full = OFF_SUM_W'(drow) * OFF_SUM_W'(ROW_PITCH)
			+ OFF_SUM_W'(cfg.dst_left) + OFF_SUM_W'(in_beat.item.col);
	end

	assign load     = !valid_q || out_ready;
	assign in_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			sfs_q  <= in_beat.item.src_frame;
			dfs_q  <= in_beat.item.dst_frame;
			soff_q <= we ? soff_full[SRC_OFF_W-1:0] : '0;
			doff_q <= doff_full[DST_OFF_W-1:0];
			we_q   <= we;
		end
	end

	assign out_valid     = valid_q;
	assign src_frame_sel = sfs_q;
	assign src_offset    = soff_q;
	assign dst_frame_sel = dfs_q;
	assign dst_offset    = doff_q;
	assign write_enable  = we_q;

endmodule

// File: hdl/nearest_scale_blit_address_gen_unit.sv
// ----------------------------------------------------------------------------
// nearest_scale_blit_address_gen_unit: nearest-neighbor scaling blit addresses
// Stages: multiply, 10 divider cells and offset stage, each registered.
// Throughput: one beat per cycle while the sink takes results, set by the
//   divider chain retiring one quotient bit per cell per cycle.
// Reset: clears all stage valids and the rectangle registers to zero.
// ----------------------------------------------------------------------------
module nearest_scale_blit_address_gen_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [8:0] col, [17:9] row, [19:18] src_frame, [21:20] dst_frame, rest zero
	input  logic [nsbd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] command
	input  logic [nsbd_pkg::CMD_W-1:0]          s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [1:0] src_frame_sel, [19:2] src_offset, [21:20] dst_frame_sel,
	// [40:22] dst_offset, rest zero
	output logic [nsbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [0] write_enable
	output logic                                m_axis_tuser,
	// register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nsbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nsbd_pkg::SIZE_W-1:0]         cfg_data
);
	import nsbd_pkg::*;

	// Rectangle registers. The user must write them only while the pipe is empty (the
	// block does not enforce it), so every stage reads them directly instead of carrying a copy per beat.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_LEFT:   cfg_q.src_left   <= cfg_data[POS_W-1:0];
				REG_SRC_TOP:    cfg_q.src_top    <= cfg_data[POS_W-1:0];
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data;
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				REG_DST_LEFT:   cfg_q.dst_left   <= cfg_data[POS_W-1:0];
				REG_DST_TOP:    cfg_q.dst_top    <= cfg_data[POS_W-1:0];
				REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data;
				REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data;
			endcase
		end
	end

	// Unpack the input beat.
	item_t in_item;

	always_comb begin
		in_item.command   = s_axis_tuser;
		in_item.col       = s_axis_tdata[8:0];
		in_item.row       = s_axis_tdata[17:9];
		in_item.src_frame = s_axis_tdata[19:18];
		in_item.dst_frame = s_axis_tdata[21:20];
	end

	// Handshake nodes between stages: node 0 is the front stage output,
	// node NUM_CELLS feeds the offset stage. Each stage is ready when empty
	// or when its successor moves, so bubbles close up under back-pressure.
	logic      node_valid [NUM_CELLS+1];
	logic      node_ready [NUM_CELLS+1];
	div_beat_t node_beat  [NUM_CELLS+1];

	nsbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (node_valid[0]),
		.out_ready (node_ready[0]),
		.out_beat  (node_beat[0])
	);

	// Divider chain: each cell resolves one quotient bit, MSB first, for the
	// column lane and the row lane side by side.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		nsbd_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (node_valid[i]),
			.in_ready  (node_ready[i]),
			.in_beat   (node_beat[i]),
			.out_valid (node_valid[i+1]),
			.out_ready (node_ready[i+1]),
			.out_beat  (node_beat[i+1])
		);
	end

	logic [FRAME_W-1:0]   res_sfs, res_dfs;
	logic [SRC_OFF_W-1:0] res_soff;
	logic [DST_OFF_W-1:0] res_doff;
	logic                 res_we;

	nsbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (node_valid[NUM_CELLS]),
		.in_ready      (node_ready[NUM_CELLS]),
		.in_beat       (node_beat[NUM_CELLS]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.src_frame_sel (res_sfs),
		.src_offset    (res_soff),
		.dst_frame_sel (res_dfs),
		.dst_offset    (res_doff),
		.write_enable  (res_we)
	);

	// Pack the result beat.
	assign m_axis_tdata = {(OUT_DATA_W - 41)'(0), res_doff, res_dfs, res_soff, res_sfs};
	assign m_axis_tuser = res_we;

	// A granted source offset always lies inside one frame.
	a_src_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_we |-> res_soff < SRC_OFF_W'(FRAME_ROWS * ROW_PITCH))
		else $error("source offset beyond frame with write enabled");

	// Skipped pixels carry a zero source offset.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res_we |-> res_soff == '0)
		else $error("skipped pixel with nonzero source offset");

	// Input back-pressure only comes from a full pipe behind a stalled sink.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

endmodule

// File: tb/nearest_scale_blit_address_gen_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_scale_blit_address_gen_unit_test: self-checking bench for the blit
// address generator
// Drives pixel beats and rectangle register writes and predicts every result
// beat in a scoreboard. Directed corners first, then random rectangles with
// random stalls on both streams.
// ----------------------------------------------------------------------------
module nearest_scale_blit_address_gen_unit_test;
	import nsbd_pkg::*;

	localparam int LATENCY     = 12;      // input beat to result beat
	localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 100;
	localparam int IDLE_PCT    = 10;
	localparam int MAX_REPORTS = 10;

	// Command code the block has no mode for; must give a skipped pixel.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One result beat, unpacked.
	typedef struct {
		logic [FRAME_W-1:0]   src_sel;
		logic [SRC_OFF_W-1:0] src_off;
		logic [FRAME_W-1:0]   dst_sel;
		logic [DST_OFF_W-1:0] dst_off;
		logic                 wr_en;
	} blit_addr_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the rectangle registers, address predictor and
	// the queue of addresses still owed by the block.
	// ------------------------------------------------------------------------
	class blit_scoreboard;
		cfg_t       rect;
		blit_addr_t owed_q[$];
		int         mismatches;
		int         checked;

		function new();
			rect       = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Mirror a register write; position registers keep 9 bits.
		function void write_reg(reg_idx_t idx, logic [SIZE_W-1:0] value);
			case (idx)
				REG_SRC_LEFT:   rect.src_left   = value[POS_W-1:0];
				REG_SRC_TOP:    rect.src_top    = value[POS_W-1:0];
				REG_SRC_WIDTH:  rect.src_width  = value;
				REG_SRC_HEIGHT: rect.src_height = value;
				REG_DST_LEFT:   rect.dst_left   = value[POS_W-1:0];
				REG_DST_TOP:    rect.dst_top    = value[POS_W-1:0];
				REG_DST_WIDTH:  rect.dst_width  = value;
				REG_DST_HEIGHT: rect.dst_height = value;
				default: ;
			endcase
		endfunction

		// Work out the addresses for one accepted pixel beat.
		function void note_item(item_t it);
			blit_addr_t r;
			longint c, rw, sl, st, sw, sh, dl, dt, dw, dh, sx, sy;
			bit ok;
			c  = it.col;            rw = it.row;
			sl = rect.src_left;     st = rect.src_top;
			sw = rect.src_width;    sh = rect.src_height;
			dl = rect.dst_left;     dt = rect.dst_top;
			dw = rect.dst_width;    dh = rect.dst_height;
			sx = 0;
			sy = 0;
			ok = 1'b1;
			if (sw == 0 || sh == 0 || dw == 0 || dh == 0)
				ok = 1'b0;       // empty rectangle: never divide
			else if (c >= dw || rw >= dh)
				ok = 1'b0;       // pixel outside the destination rectangle
			else begin
				case (it.command)
					CMD_SCALE: begin
						sx = sl + (sw * c) / dw;
						sy = st + (sh * rw) / dh;
					end
					CMD_MIRROR: begin
						sx = sl + sw - 1 - (sw * c) / dw;
						sy = st + sh - 1 - (sh * rw) / dh;
					end
					CMD_TURN: begin
						sx = sl + sw - 1 - (sw * rw) / dh;
						sy = st + (sh * c) / dw;
					end
					default: ok = 1'b0;
				endcase
			end
			if (ok && (sx < 0 || sx >= ROW_PITCH || sy < 0 || sy >= FRAME_ROWS))
				ok = 1'b0;       // source pixel off the frame
			r.src_sel = it.src_frame;
			r.dst_sel = it.dst_frame;
			r.dst_off = DST_OFF_W'((dt + rw) * ROW_PITCH + dl + c);
			r.src_off = ok ? SRC_OFF_W'(sy * ROW_PITCH + sx) : '0;
			r.wr_en   = ok;
			owed_q.push_back(r);
		endfunction

		// Compare one result beat with the oldest owed address.
		function void check_result(logic [OUT_DATA_W-1:0] d, logic u);
			blit_addr_t e, got;
			got.src_sel = d[1:0];
			got.src_off = d[19:2];
			got.dst_sel = d[21:20];
			got.dst_off = d[40:22];
			got.wr_en   = u;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result beat with nothing owed: data %h we %b", d, u);
				return;
			end
			e = owed_q.pop_front();
			checked++;
			if (got.src_sel !== e.src_sel || got.src_off !== e.src_off ||
			    got.dst_sel !== e.dst_sel || got.dst_off !== e.dst_off ||
			    got.wr_en !== e.wr_en) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"ERROR: result %0d: exp sfr %0d soff %0d dfr %0d doff %0d we %b",
					          " / got sfr %0d soff %0d dfr %0d doff %0d we %b"},
					         checked, e.src_sel, e.src_off, e.dst_sel, e.dst_off, e.wr_en,
					         got.src_sel, got.src_off, got.dst_sel, got.dst_off, got.wr_en);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [CMD_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SIZE_W-1:0]     cfg_data;

	nearest_scale_blit_address_gen_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	blit_scoreboard sb = new();

	logic no_idle;          // set during the stall-free stretch
	int   cycle_count = 0;
	int   items_sent  = 0;
	int   settings    = 0;

	// 8-unit clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results owed",
			         cycle_count, sb.pending());
			$display("nearest_scale_blit_address_gen_unit_test: FAIL");
			$finish;
		end
	end

	// Result sink: random back-pressure, changed on the falling edge.
	always @(negedge clk)
		m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	// Result monitor: a beat moves when valid and ready meet at the edge.
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);

	// ------------------------------------------------------------------------
	// Drivers. All tasks start and end on a falling edge.
	// ------------------------------------------------------------------------

	// One pixel beat; random gaps ahead of it. Valid stays high between
	// back-to-back beats, so it gets one assignment per falling edge.
	task automatic send_pixel(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] col,
	                          input logic [POS_W-1:0] row, input logic [FRAME_W-1:0] sfr,
	                          input logic [FRAME_W-1:0] dfr);
		item_t it;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {2'b00, dfr, sfr, row, col};
		s_axis_tuser  = cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		it.command   = cmd;
		it.col       = col;
		it.row       = row;
		it.src_frame = sfr;
		it.dst_frame = dfr;
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic program_reg(input reg_idx_t idx, input logic [SIZE_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Whole rectangle set. Position registers get a random junk bit 9,
	// which the block must drop.
	task automatic set_rect(input int sl, input int st, input int sw, input int sh,
	                        input int dl, input int dt, input int dw, input int dh);
		program_reg(REG_SRC_LEFT,   SIZE_W'(sl) | (SIZE_W'($urandom_range(1)) << POS_W));
		program_reg(REG_SRC_TOP,    SIZE_W'(st) | (SIZE_W'($urandom_range(1)) << POS_W));
		program_reg(REG_SRC_WIDTH,  SIZE_W'(sw));
		program_reg(REG_SRC_HEIGHT, SIZE_W'(sh));
		program_reg(REG_DST_LEFT,   SIZE_W'(dl) | (SIZE_W'($urandom_range(1)) << POS_W));
		program_reg(REG_DST_TOP,    SIZE_W'(dt) | (SIZE_W'($urandom_range(1)) << POS_W));
		program_reg(REG_DST_WIDTH,  SIZE_W'(dw));
		program_reg(REG_DST_HEIGHT, SIZE_W'(dh));
		settings++;
	endtask

	// Wait until every owed result came back, then let the pipe run dry.
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Rectangle size: mostly anywhere, with zero, one and full size mixed in.
	function automatic int pick_size();
		case ($urandom_range(19))
			0:       return 0;
			1:       return 512;
			2:       return 1;
			3, 4:    return $urandom_range(16, 1);
			default: return $urandom_range(512, 1);
		endcase
	endfunction

	// Position: often near the origin so the source stays on the frame.
	function automatic int pick_pos(input int span);
		if ($urandom_range(99) < 40)
			return $urandom_range(511);
		return $urandom_range(span);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int ph, n, sw, sh, dw, dh, col, row;
		logic [CMD_W-1:0] cmd;

		arst_n        = 1'b0;
		no_idle       = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_SRC_LEFT;
		cfg_data      = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Registers at reset are all zero: every pixel is skipped, and the
		// destination offset still comes through.
		send_pixel(CMD_SCALE, 9'd0, 9'd0, 2'd0, 2'd0);
		send_pixel(CMD_MIRROR, 9'd511, 9'd511, 2'd3, 2'd3);
		settle();

		// Full-width source on the frame, largest destination: all modes at
		// both corners, plus the unused command.
		set_rect(0, 0, 512, 272, 0, 0, 512, 512);
		send_pixel(CMD_SCALE,  9'd0,   9'd0,   2'd1, 2'd2);
		send_pixel(CMD_SCALE,  9'd511, 9'd511, 2'd2, 2'd1);
		send_pixel(CMD_MIRROR, 9'd0,   9'd0,   2'd3, 2'd0);
		send_pixel(CMD_MIRROR, 9'd511, 9'd511, 2'd0, 2'd3);
		send_pixel(CMD_TURN,   9'd0,   9'd0,   2'd1, 2'd1);
		send_pixel(CMD_TURN,   9'd511, 9'd511, 2'd2, 2'd2);
		send_pixel(CMD_UNUSED, 9'd5,   9'd5,   2'd3, 2'd3);
		settle();

		// Positions at the top of their range, 512 source sizes, one-pixel
		// destination: source off the frame, and pixels outside the destination rectangle.
		set_rect(511, 511, 512, 512, 511, 511, 1, 1);
		send_pixel(CMD_SCALE,  9'd0,   9'd0,   2'd0, 2'd1);
		send_pixel(CMD_SCALE,  9'd1,   9'd0,   2'd1, 2'd0);
		send_pixel(CMD_MIRROR, 9'd0,   9'd1,   2'd2, 2'd3);
		send_pixel(CMD_TURN,   9'd0,   9'd0,   2'd3, 2'd2);
		settle();

		// Source on the frame's last row and column.
		set_rect(511, 271, 1, 1, 0, 0, 1, 1);
		send_pixel(CMD_SCALE,  9'd0, 9'd0, 2'd0, 2'd0);
		send_pixel(CMD_TURN,   9'd0, 9'd0, 2'd3, 2'd3);
		settle();

		// Source sizes past 512: quotients need all ten bits, and the
		// mirrored pick lands back on the frame.
		set_rect(5, 0, 1023, 1023, 0, 0, 3, 300);
		send_pixel(CMD_MIRROR, 9'd2, 9'd299, 2'd1, 2'd2);
		send_pixel(CMD_TURN,   9'd2, 9'd299, 2'd2, 2'd1);
		send_pixel(CMD_SCALE,  9'd2, 9'd0,   2'd3, 2'd0);
		send_pixel(CMD_MIRROR, 9'd1, 9'd250, 2'd0, 2'd3);
		settle();

		// One zero size in the source, then one in the destination.
		set_rect(3, 4, 0, 20, 5, 6, 20, 20);
		send_pixel(CMD_SCALE, 9'd2, 9'd2, 2'd1, 2'd2);
		settle();
		set_rect(3, 4, 20, 20, 5, 6, 20, 0);
		send_pixel(CMD_TURN, 9'd2, 9'd0, 2'd2, 2'd1);
		settle();

		// Random rectangles; two phases run with no stalls on either side.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			no_idle = (ph == 4 || ph == 5);
			sw = pick_size();
			sh = pick_size();
			dw = pick_size();
			dh = pick_size();
			set_rect(pick_pos(64), pick_pos(64), sw, sh, pick_pos(511), pick_pos(511), dw, dh);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				cmd = ($urandom_range(19) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(2));
				// mostly inside the destination rectangle, some anywhere
				if (dw != 0 && $urandom_range(99) < 85)
					col = $urandom_range(dw - 1);
				else
					col = $urandom_range(511);
				if (dh != 0 && $urandom_range(99) < 85)
					row = $urandom_range(dh - 1);
				else
					row = $urandom_range(511);
				send_pixel(cmd, POS_W'(col), POS_W'(row),
				           FRAME_W'($urandom_range(3)), FRAME_W'($urandom_range(3)));
			end
			settle();
		end
		no_idle = 1'b0;

		// Anything still owed here is a lost result.
		sb.mismatches += sb.pending();

		$display("Run covered %0d pixel beats over %0d rectangle settings, %0d results checked.",
		         items_sent, settings, sb.checked);
		$display("Mismatches: %0d (first %0d shown).", sb.mismatches, MAX_REPORTS);
		if (sb.mismatches == 0)
			$display("nearest_scale_blit_address_gen_unit_test: PASS");
		else
			$display("nearest_scale_blit_address_gen_unit_test: FAIL");
		$finish;
	end

endmodule
